### rtl/bdar_pkg.sv
// Shared types and constants for the button debounce / auto-repeat block.
// No dependencies; imported by every module under rtl.
`default_nettype none

package bdar_pkg;

  // Field and counter widths fixed by the block's interface.
  localparam int unsigned RAW_W   = 4;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CFG_AW  = 2;

  localparam int unsigned NUM_BUTTONS_DEF = 4;

  // Register reset values
  localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [TICK_W-1:0] DELAY_RST    = 16'd300;
  localparam logic [TICK_W-1:0] PERIOD_RST   = 16'd100;
  localparam logic [TICK_W-1:0] TICK_MAX     = 16'hFFFF;

  // Register indexes on the write port
  typedef enum logic [CFG_AW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_DELAY    = 2'd1,
    CFG_PERIOD   = 2'd2
  } cfg_idx_e;

  // Timing settings handed to every lane
  typedef struct packed {
    logic [TICK_W-1:0] debounce;
    logic [TICK_W-1:0] delay;
    logic [TICK_W-1:0] period;
  } cfg_t;

  // What one lane found on the current tick
  typedef struct packed {
    logic change;   // debounced level change accepted
    logic rel;      // that change was a release
    logic rpt;      // auto-repeat press
  } lane_ev_t;

  // Merger status seen by the top level
  typedef struct packed {
    logic pend_any;   // events still queued behind the output register
    logic can_load;   // a new tick may be taken this cycle
  } merge_stat_t;

endpackage

`default_nettype wire

### rtl/button_debounce_autorepeat_core.sv
// Button debouncer with auto-repeat: input skid-free tick channel, one lane per
// button, event merger and output register. Uses bdar_pkg, bdar_lane, bdar_merge.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / raw_buttons_i): one item per
//    millisecond tick, bit i = button i, 1 = released, 0 = pressed.
//  - Output channel (out_valid_o / out_stall_i): one item per event with
//    button_index_o, is_release_o and last_of_run_o (set on the tick's final
//    event). A tick may cause 0 to NUM_BUTTONS events, none for a quiet tick.
//  - Event path: the first event of a tick passes through the queue register, then the output register.
//  - Throughput: one event per cycle while out_stall_i is low, set by the single
//    output register of the merger. The next tick is taken in the cycle the last
//    queued event moves to the output register.
//  - Stall: while out_stall_i is high a valid output holds and queued events wait;
//    in_stall_o rises once events remain queued.
//  - Reset: all buttons released, repeat off, counts zero, registers 50/300/100.
//  - Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//    (0 debounce, 1 repeat delay, 2 repeat period); index 3 is ignored.
`default_nettype none

module button_debounce_autorepeat_core
  import bdar_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = NUM_BUTTONS_DEF
)(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_idx_i,
  input  wire logic [TICK_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [RAW_W-1:0]  raw_buttons_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [IDX_W-1:0]       button_index_o,
  output logic                   is_release_o,
  output logic                   last_of_run_o
);

  cfg_t                   cfg_q;
  merge_stat_t            stat;
  lane_ev_t               lane_ev [NUM_BUTTONS];
  logic [2*NUM_BUTTONS-1:0] ev_vec;
  logic [NUM_BUTTONS-1:0] rel_vec;
  logic                   step;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce <= DEBOUNCE_RST;
      cfg_q.delay    <= DELAY_RST;
      cfg_q.period   <= PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE: cfg_q.debounce <= cfg_wdata_i;
        CFG_DELAY:    cfg_q.delay    <= cfg_wdata_i;
        CFG_PERIOD:   cfg_q.period   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign step       = in_valid_i && stat.can_load;
  assign in_stall_o = !stat.can_load;

  // One lane per button; buttons beyond the pins read as pressed
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic raw_bit;
    if (b < RAW_W) begin : g_pin
      assign raw_bit = raw_buttons_i[b];
    end else begin : g_nopin
      assign raw_bit = 1'b0;
    end

    bdar_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (step),
      .raw_i  (raw_bit),
      .cfg_i  (cfg_q),
      .ev_o   (lane_ev[b])
    );

    assign ev_vec[b]               = lane_ev[b].change;
    assign ev_vec[NUM_BUTTONS + b] = lane_ev[b].rpt;
    assign rel_vec[b]              = lane_ev[b].rel;
  end

  bdar_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (step),
    .ev_i           (ev_vec),
    .rel_i          (rel_vec),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .button_index_o (button_index_o),
    .is_release_o   (is_release_o),
    .last_of_run_o  (last_of_run_o),
    .stat_o         (stat)
  );

`ifndef SYNTHESIS
  // An event that is not the last of its tick always has successors queued
  a_more_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> stat.pend_any)
    else $error("non-final event with empty queue");

  // A tick that causes events leaves them queued or on the output
  a_tick_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (ev_vec != '0) |=> stat.pend_any || out_valid_o)
    else $error("events of an accepted tick lost");

  // Never take a tick while events from the previous one remain behind
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pend_any && out_valid_o && out_stall_i |-> in_stall_o)
    else $error("tick accepted over queued events");
`endif

endmodule

`default_nettype wire

### rtl/bdar_lane.sv
// One button lane: holds stable level, repeat flag and tick count,
// and evaluates both passes for its button on each tick. Uses bdar_pkg.
`default_nettype none

module bdar_lane
  import bdar_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire logic     raw_i,
  input  wire cfg_t     cfg_i,
  output lane_ev_t      ev_o
);

  logic              stable_q, stable_d;
  logic              rep_q, rep_d;
  logic [TICK_W-1:0] cnt_q, cnt_d;

  logic              accept;
  logic              stable1, rep1;
  logic [TICK_W-1:0] cnt_inc, cnt1;

  // Pass one: saturating count, then debounced change
  always_comb begin
    cnt_inc = (cnt_q == TICK_MAX) ? cnt_q : cnt_q + 1'b1;
    accept  = (raw_i != stable_q) && (cnt_inc >= cfg_i.debounce);
    stable1 = accept ? raw_i : stable_q;
    rep1    = (accept && raw_i) ? 1'b0 : rep_q;
    cnt1    = accept ? '0 : cnt_inc;
  end

  // Pass two: arm repeat after the delay, then press every period
  always_comb begin
    stable_d  = stable1;
    rep_d     = rep1;
    cnt_d     = cnt1;
    ev_o.change = accept;
    ev_o.rel    = raw_i;
    ev_o.rpt    = 1'b0;
    if (!stable1) begin
      if (!rep1) begin
        if (cnt1 >= cfg_i.delay) begin
          rep_d = 1'b1;
          cnt_d = '0;
        end
      end else if (cnt1 >= cfg_i.period) begin
        ev_o.rpt = 1'b1;
        cnt_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      rep_q    <= 1'b0;
      cnt_q    <= '0;
    end else if (step_i) begin
      stable_q <= stable_d;
      rep_q    <= rep_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/bdar_merge.sv
// Merging stage: queues the events of one tick in order (changes by button,
// then repeats by button) and sends them one per cycle while out_stall_i is low. Uses bdar_pkg.
`default_nettype none

module bdar_merge
  import bdar_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = NUM_BUTTONS_DEF
)(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     load_i,
  input  wire logic [2*NUM_BUTTONS-1:0] ev_i,
  input  wire logic [NUM_BUTTONS-1:0]   rel_i,
  input  wire logic                     out_stall_i,
  output logic                          out_valid_o,
  output logic [IDX_W-1:0]              button_index_o,
  output logic                          is_release_o,
  output logic                          last_of_run_o,
  output merge_stat_t                   stat_o
);

  localparam int unsigned PW = 2 * NUM_BUTTONS;
  localparam int unsigned IW = $clog2(PW);
  localparam int unsigned BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [PW-1:0]          pend_q, pend_d;
  logic [NUM_BUTTONS-1:0] rel_q;
  logic                   out_valid_q;
  logic [IDX_W-1:0]       idx_q;
  logic                   rel_out_q, last_q;

  logic [PW-1:0] lowbit, rest, pend_after;
  logic [IW-1:0] sel;
  logic [BW-1:0] btn;
  logic [15:0]   btn_ext;
  logic          pass_one, slot_free, move;

  // Lowest queued event and its button
  always_comb begin
    lowbit = pend_q & (~pend_q + 1'b1);
    rest   = pend_q & ~lowbit;
    sel    = '0;
    for (int j = 0; j < PW; j++) begin
      if (lowbit[j]) sel = sel | IW'(j);
    end
    pass_one = (32'(sel) < NUM_BUTTONS);
    btn      = pass_one ? BW'(sel) : BW'(32'(sel) - NUM_BUTTONS);
    btn_ext  = 16'(btn);
  end

  // Queue advance and load condition
  always_comb begin
    slot_free  = !out_valid_q || !out_stall_i;
    move       = slot_free && (pend_q != '0);
    pend_after = move ? rest : pend_q;
    pend_d     = load_i ? ev_i : pend_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (slot_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load_i) rel_q <= rel_i;
    if (move) begin
      idx_q     <= btn_ext[IDX_W-1:0];
      rel_out_q <= pass_one && rel_q[btn];
      last_q    <= (rest == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign button_index_o  = idx_q;
  assign is_release_o    = rel_out_q;
  assign last_of_run_o   = last_q;
  assign stat_o.pend_any = (pend_q != '0);
  assign stat_o.can_load = (pend_after == '0);

endmodule

`default_nettype wire

### test/tb_button_debounce_autorepeat_core.sv
// Testbench for button_debounce_autorepeat_core: directed ticks and random
// bounce traffic, checked against an in-bench predictor.
// Depends on rtl/bdar_pkg.sv and rtl/button_debounce_autorepeat_core.sv.
`timescale 1ns / 100ps

module tb_button_debounce_autorepeat_core;
  import bdar_pkg::*;

  localparam int NB            = NUM_BUTTONS_DEF;
  localparam int SETTLE_CYC    = 12;
  localparam int RAND_PHASES   = 4;
  localparam int PHASE_TICKS   = 72;
  localparam int MAX_PRINTS    = 40;
  localparam int N_DIRECTED    = 25;
  localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;  // unmapped index, write is dropped

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             rel;
    logic             is_last;
  } btn_event_t;

  typedef enum {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [RAW_W-1:0]  raw;
    logic [TICK_W-1:0] deb;
    logic [TICK_W-1:0] dly;
    logic [TICK_W-1:0] per;
    int                exp_n;   // typed event count, -1 = predictor only
  } stim_row_t;

  // DUT ports
  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_AW-1:0] cfg_idx_i;
  logic [TICK_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [RAW_W-1:0]  raw_buttons_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [IDX_W-1:0]  button_index_o;
  logic              is_release_o;
  logic              last_of_run_o;

  // predictor state and timing settings
  logic [RAW_W-1:0]  pr_level;
  logic [RAW_W-1:0]  pr_repeat;
  logic [TICK_W-1:0] pr_age [NB];
  logic [TICK_W-1:0] pr_debounce;
  logic [TICK_W-1:0] pr_delay;
  logic [TICK_W-1:0] pr_period;

  btn_event_t pending_events [$];
  btn_event_t want;

  int errors;
  int ticks_sent;
  int events_seen;
  int settings_used;
  int burst_left;
  bit sender_gaps_on;

  // directed ticks: reset defaults, zero settings, bounce, full-range settings
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_TICK, 4'hF, 16'd0, 16'd0, 16'd0, 0},
    '{ROW_TICK, 4'h0, 16'd0, 16'd0, 16'd0, 0},
    '{ROW_CFG,  4'hF, 16'd0, 16'd0, 16'd0, -1},
    '{ROW_TICK, 4'h0, 16'd0, 16'd0, 16'd0, 4},
    '{ROW_TICK, 4'h0, 16'd0, 16'd0, 16'd0, 4},
    '{ROW_TICK, 4'hF, 16'd0, 16'd0, 16'd0, 4},
    '{ROW_TICK, 4'hF, 16'd0, 16'd0, 16'd0, 0},
    '{ROW_TICK, 4'hA, 16'd0, 16'd0, 16'd0, 2},
    '{ROW_TICK, 4'h5, 16'd0, 16'd0, 16'd0, 4},
    '{ROW_CFG,  4'hF, 16'd2, 16'd3, 16'd1, -1},
    '{ROW_TICK, 4'h5, 16'd0, 16'd0, 16'd0, -1},
    '{ROW_TICK, 4'h0, 16'd0, 16'd0, 16'd0, -1},
    '{ROW_TICK, 4'h5, 16'd0, 16'd0, 16'd0, -1},
    '{ROW_TICK, 4'h5, 16'd0, 16'd0, 16'd0, -1},
    '{ROW_TICK, 4'hF, 16'd0, 16'd0, 16'd0, -1},
    '{ROW_TICK, 4'hF, 16'd0, 16'd0, 16'd0, -1},
    '{ROW_TICK, 4'hF, 16'd0, 16'd0, 16'd0, -1},
    '{ROW_TICK, 4'h0, 16'd0, 16'd0, 16'd0, -1},
    '{ROW_TICK, 4'h0, 16'd0, 16'd0, 16'd0, -1},
    '{ROW_TICK, 4'h0, 16'd0, 16'd0, 16'd0, -1},
    '{ROW_TICK, 4'h0, 16'd0, 16'd0, 16'd0, -1},
    '{ROW_TICK, 4'h0, 16'd0, 16'd0, 16'd0, -1},
    '{ROW_CFG,  4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, -1},
    '{ROW_TICK, 4'hF, 16'd0, 16'd0, 16'd0, 0},
    '{ROW_TICK, 4'h0, 16'd0, 16'd0, 16'd0, 0}
  };

  button_debounce_autorepeat_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_buttons_i  (raw_buttons_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .button_index_o (button_index_o),
    .is_release_o   (is_release_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // one tick: bump ages, accept debounced changes, then run auto-repeat
  function automatic int predict_tick(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] diff;
    btn_event_t evs [$];
    int n;
    for (int b = 0; b < NB; b++)
      if (pr_age[b] != TICK_MAX) pr_age[b]++;
    diff = raw ^ pr_level;
    for (int b = 0; b < NB; b++) begin
      if (diff[b] && pr_age[b] >= pr_debounce) begin
        evs.push_back('{idx: IDX_W'(b), rel: raw[b], is_last: 1'b0});
        pr_age[b]   = '0;
        pr_level[b] = raw[b];
        if (raw[b]) pr_repeat[b] = 1'b0;
      end
    end
    for (int b = 0; b < NB; b++) begin
      if (!pr_level[b]) begin
        if (!pr_repeat[b]) begin
          // arming is silent
          if (pr_age[b] >= pr_delay) begin
            pr_repeat[b] = 1'b1;
            pr_age[b]    = '0;
          end
        end else if (pr_age[b] >= pr_period) begin
          evs.push_back('{idx: IDX_W'(b), rel: 1'b0, is_last: 1'b0});
          pr_age[b] = '0;
        end
      end
    end
    n = evs.size();
    if (n > 0) evs[n-1].is_last = 1'b1;
    foreach (evs[i]) pending_events.push_back(evs[i]);
    return n;
  endfunction

  // offer one tick, wait for it to be taken; sender works in bursts, with gaps when sender_gaps_on is set
  task automatic send_tick(input logic [RAW_W-1:0] raw, output int n_ev);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    raw_buttons_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    n_ev = predict_tick(raw);
    ticks_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // drain the block before touching the registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic load_timing(input logic [TICK_W-1:0] deb, dly, per);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DEBOUNCE;
    cfg_wdata_i <= deb;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_DELAY;
    cfg_wdata_i <= dly;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_PERIOD;
    cfg_wdata_i <= per;
    @(negedge clk_i);
    // unmapped index must leave everything alone
    cfg_idx_i   <= CFG_SPARE;
    cfg_wdata_i <= 16'($urandom);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    pr_debounce = deb;
    pr_delay    = dly;
    pr_period   = per;
    settings_used++;
    @(negedge clk_i);
  endtask

  // random traffic: mostly held levels with occasional bounce, some pure noise
  task automatic run_random_phase(input int n_ticks);
    logic [RAW_W-1:0] level;
    logic [RAW_W-1:0] raw;
    int hold;
    int n_ev;
    level = pr_level;
    for (int t = 0; t < n_ticks; ) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 1) != 0) level = level ^ (4'b0001 << $urandom_range(0, 3));
        else level = RAW_W'($urandom);
        hold = $urandom_range(1, 24);
        repeat (hold) begin
          raw = level;
          if ($urandom_range(0, 7) == 0) raw = level ^ RAW_W'($urandom_range(1, 15));
          send_tick(raw, n_ev);
          t++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_tick(RAW_W'($urandom), n_ev);
          t++;
        end
      end
    end
  endtask

  // receiver stall, switching between a few patterns
  initial begin
    int stall_mode;
    int run_len;
    int cyc;
    out_stall_i = 1'b0;
    cyc = 0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      run_len    = $urandom_range(16, 96);
      repeat (run_len) begin
        @(negedge clk_i);
        cyc++;
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 9) < 6);
          default: out_stall_i <= (cyc % 8) < 5;
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected event: button %0d rel %0b last %0b",
                         button_index_o, is_release_o, last_of_run_o));
      end else begin
        want = pending_events.pop_front();
        if (button_index_o !== want.idx || is_release_o !== want.rel ||
            last_of_run_o !== want.is_last)
          report($sformatf("event got button %0d rel %0b last %0b, want %0d %0b %0b",
                           button_index_o, is_release_o, last_of_run_o,
                           want.idx, want.rel, want.is_last));
      end
    end
  end

  initial begin
    int n_ev;
    errors         = 0;
    ticks_sent     = 0;
    events_seen    = 0;
    settings_used  = 0;
    burst_left     = 0;
    sender_gaps_on = 1'b1;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_DEBOUNCE;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    raw_buttons_i  = '1;
    // predictor reset: all released, repeat off, ages zero
    pr_level    = '1;
    pr_repeat   = '0;
    pr_debounce = DEBOUNCE_RST;
    pr_delay    = DELAY_RST;
    pr_period   = PERIOD_RST;
    for (int b = 0; b < NB; b++) pr_age[b] = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_idle();
        load_timing(directed_rows[r].deb, directed_rows[r].dly, directed_rows[r].per);
      end else begin
        send_tick(directed_rows[r].raw, n_ev);
        if (directed_rows[r].exp_n >= 0 && n_ev != directed_rows[r].exp_n)
          report($sformatf("directed row %0d: %0d events predicted, %0d typed",
                           r, n_ev, directed_rows[r].exp_n));
      end
    end

    // random phases, one with all-zero timing
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      if (p == 1) load_timing('0, '0, '0);
      else load_timing(TICK_W'($urandom_range(0, 6)), TICK_W'($urandom_range(0, 20)),
                       TICK_W'($urandom_range(0, 8)));
      sender_gaps_on = (p != 2);
      run_random_phase(PHASE_TICKS);
    end
    in_valid_i <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("run covered %0d ticks over %0d timing settings", ticks_sent, settings_used);
    $display("%0d button events checked, %0d mismatches", events_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
